FILE: hw/rtl/bb3_pkg.sv
// ============================================================================
// bb3_pkg: shared types and constants of the 3x3 box blur stream
// Pixel, window column and sum types, register indexes, mean reciprocals.
// ============================================================================
package bb3_pkg;

    localparam int TDATA_W      = 24;
    localparam int CFG_INDEX_W  = 2;
    localparam int CFG_DATA_W   = 13;
    localparam int WIDTH_FIELD_W = 11;
    localparam int HEIGHT_W     = 13;
    localparam int OROW_W       = 12;
    localparam int HEIGHT_MAX   = 4096;
    localparam int HEIGHT_RESET = 1024;
    localparam int RECIP_SHIFT  = 20;

    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_FLUSH = 1'b1;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } pixel_t;

    // one window column: bottom is the newest row
    typedef struct packed {
        pixel_t bottom;
        pixel_t middle;
        pixel_t top;
    } column_t;

    typedef struct packed {
        logic [9:0] red;
        logic [9:0] green;
        logic [9:0] blue;
    } csum_t;

    typedef struct packed {
        logic [11:0] red;
        logic [11:0] green;
        logic [11:0] blue;
    } sum_t;

    // emit flag, neighborhood masks and last flag of the output pixel an item produces
    typedef struct packed {
        logic emit;
        logic top_ok;
        logic bot_ok;
        logic left_ok;
        logic right_ok;
        logic last;
    } tap_ctl_t;

    // ceil(2^20 / (2 * count)) for count 1..9
    function automatic logic [19:0] recip_2n(input logic [3:0] count);
        logic [19:0] m;
        case (count)
            4'd1: m = 20'd524288;
            4'd2: m = 20'd262144;
            4'd3: m = 20'd174763;
            4'd4: m = 20'd131072;
            4'd5: m = 20'd104858;
            4'd6: m = 20'd87382;
            4'd7: m = 20'd74899;
            4'd8: m = 20'd65536;
            4'd9: m = 20'd58255;
            default: m = 20'd524288;
        endcase
        return m;
    endfunction

endpackage

FILE: hw/rtl/box_blur_3x3_stream.sv
// ============================================================================
// box_blur_3x3_stream: streaming 3x3 box blur of an RGB frame
// Raster-order pixels in, per-channel rounded neighborhood means out.
// ============================================================================
// Usage:
//   Write image_width (index 0) and image_height (index 1) on the cfg channel
//   while the block is idle; a write to either register restarts the frame.
//   Widths of 0 act as 1 and widths above MAX_WIDTH saturate; heights
//   likewise clamp to 1..4096. Send pixels on s_* in raster order with s_tuser
//   low. The result for a pixel is produced by the item width+1 positions
//   later, so after the last pixel send width+1 drain items (s_tuser high, or
//   pixels whose data is dropped). A drain item sent mid-frame is dropped with
//   no effect. m_tlast marks the final pixel of the frame; the next item
//   starts a new frame. Throughput is one item per cycle while the skid stage
//   is empty; a result is registered after the column read, the window sum
//   and the reciprocal multiply before it appears on m_*. When the receiver
//   stalls, one more result is held in a skid stage and s_tready drops until
//   it drains. Reset restores the default 1024x1024 frame and empties the
//   pipeline; the row stores need no clearing as out-of-frame rows are masked.
// ============================================================================
module box_blur_3x3_stream #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [bb3_pkg::TDATA_W-1:0]       s_tdata,   // in_red, in_green, in_blue
    input  logic                              s_tuser,   // command
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [bb3_pkg::TDATA_W-1:0]       m_tdata,   // out_red, out_green, out_blue
    output logic                              m_tlast,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [bb3_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [bb3_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import bb3_pkg::*;

    localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int LW    = $clog2(MAX_WIDTH + 2);
    localparam int WIDTH_RESET = (MAX_WIDTH < 1024) ? MAX_WIDTH : 1024;

    logic [WW-1:0]       eff_w_reg, eff_w_next;
    logic [HEIGHT_W-1:0] eff_h_reg, eff_h_next;
    logic [COL_W-1:0]    icol_reg, icol_next;
    logic [HEIGHT_W-1:0] irow_reg, irow_next;
    logic [COL_W-1:0]    ocol_reg, ocol_next;
    logic [OROW_W-1:0]   orow_reg, orow_next;
    logic [LW-1:0]       lead_reg, lead_next;

    logic       advance;
    logic       accept;
    logic       take;
    logic       in_frame;
    logic       col_end;
    logic       out_col_end;
    logic       out_row_end;
    logic       restart;
    tap_ctl_t   ctl;
    pixel_t     in_pixel;

    logic       a_valid;
    tap_ctl_t   a_ctl;
    column_t    a_column;
    logic       b_valid;
    sum_t       b_sum;
    logic [3:0] b_count;
    logic       b_last;
    pixel_t     out_pixel;

    assign cfg_ready = 1'b1;
    assign s_tready  = advance;
    assign accept    = s_tvalid && s_tready;

    assign in_pixel.red   = s_tdata[7:0];
    assign in_pixel.green = s_tdata[15:8];
    assign in_pixel.blue  = s_tdata[23:16];

    always_comb begin
        in_frame    = irow_reg < eff_h_reg;
        take        = accept && !((s_tuser == CMD_FLUSH) && in_frame);
        col_end     = WW'(icol_reg) == (eff_w_reg - WW'(1));
        out_col_end = WW'(ocol_reg) == (eff_w_reg - WW'(1));
        out_row_end = HEIGHT_W'(orow_reg) == (eff_h_reg - HEIGHT_W'(1));

        ctl.emit     = lead_reg == (LW'(eff_w_reg) + LW'(1));
        ctl.top_ok   = orow_reg != '0;
        ctl.bot_ok   = !out_row_end;
        ctl.left_ok  = ocol_reg != '0;
        ctl.right_ok = !out_col_end;
        ctl.last     = out_row_end && out_col_end;
    end

    always_comb begin
        eff_w_next = eff_w_reg;
        eff_h_next = eff_h_reg;
        icol_next  = icol_reg;
        irow_next  = irow_reg;
        ocol_next  = ocol_reg;
        orow_next  = orow_reg;
        lead_next  = lead_reg;
        restart    = 1'b0;

        if (cfg_valid) begin
            case (cfg_index)
                REG_IMAGE_WIDTH: begin
                    if (cfg_data[WIDTH_FIELD_W-1:0] == '0) begin
                        eff_w_next = WW'(1);
                    end else if (32'(cfg_data[WIDTH_FIELD_W-1:0]) > MAX_WIDTH) begin
                        eff_w_next = WW'(MAX_WIDTH);
                    end else begin
                        eff_w_next = WW'(cfg_data[WIDTH_FIELD_W-1:0]);
                    end
                    restart = 1'b1;
                end
                REG_IMAGE_HEIGHT: begin
                    if (cfg_data == '0) begin
                        eff_h_next = HEIGHT_W'(1);
                    end else if (32'(cfg_data) > HEIGHT_MAX) begin
                        eff_h_next = HEIGHT_W'(HEIGHT_MAX);
                    end else begin
                        eff_h_next = cfg_data;
                    end
                    restart = 1'b1;
                end
                default: begin
                end
            endcase
        end else if (take) begin
            if (ctl.emit && ctl.last) begin
                restart = 1'b1;
            end else begin
                // drain items keep walking the columns so the row stores line up
                icol_next = col_end ? '0 : icol_reg + COL_W'(1);
                if (col_end && in_frame) begin
                    irow_next = irow_reg + HEIGHT_W'(1);
                end
                if (ctl.emit) begin
                    ocol_next = out_col_end ? '0 : ocol_reg + COL_W'(1);
                    if (out_col_end) begin
                        orow_next = orow_reg + OROW_W'(1);
                    end
                end else begin
                    lead_next = lead_reg + LW'(1);
                end
            end
        end

        if (restart) begin
            icol_next = '0;
            irow_next = '0;
            ocol_next = '0;
            orow_next = '0;
            lead_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            eff_w_reg <= WW'(WIDTH_RESET);
            eff_h_reg <= HEIGHT_W'(HEIGHT_RESET);
            icol_reg  <= '0;
            irow_reg  <= '0;
            ocol_reg  <= '0;
            orow_reg  <= '0;
            lead_reg  <= '0;
        end else begin
            eff_w_reg <= eff_w_next;
            eff_h_reg <= eff_h_next;
            icol_reg  <= icol_next;
            irow_reg  <= irow_next;
            ocol_reg  <= ocol_next;
            orow_reg  <= orow_next;
            lead_reg  <= lead_next;
        end
    end

    bb3_line_buffer #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_line_buffer (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .advance  (advance),
        .in_valid (take),
        .in_col   (icol_reg),
        .in_pixel (in_pixel),
        .in_ctl   (ctl),
        .a_valid  (a_valid),
        .a_ctl    (a_ctl),
        .a_column (a_column)
    );

    bb3_window_sum u_window_sum (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .advance  (advance),
        .a_valid  (a_valid),
        .a_ctl    (a_ctl),
        .a_column (a_column),
        .b_valid  (b_valid),
        .b_sum    (b_sum),
        .b_count  (b_count),
        .b_last   (b_last)
    );

    bb3_mean u_mean (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .b_valid   (b_valid),
        .b_sum     (b_sum),
        .b_count   (b_count),
        .b_last    (b_last),
        .advance   (advance),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .out_pixel (out_pixel),
        .out_last  (out_last)
    );

    logic out_last;

    assign m_tdata = {out_pixel.blue, out_pixel.green, out_pixel.red};
    assign m_tlast = out_last;

endmodule

FILE: hw/rtl/bb3_line_buffer.sv
// ============================================================================
// bb3_line_buffer: two row stores and the column stage
// Reads the two previous rows at the item's column, rotates the rows back.
// ============================================================================
module bb3_line_buffer #(
    parameter int MAX_WIDTH = 1024,
    localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               advance,
    input  logic               in_valid,
    input  logic [COL_W-1:0]   in_col,
    input  bb3_pkg::pixel_t    in_pixel,
    input  bb3_pkg::tap_ctl_t  in_ctl,
    output logic               a_valid,
    output bb3_pkg::tap_ctl_t  a_ctl,
    output bb3_pkg::column_t   a_column
);
    import bb3_pkg::*;

    pixel_t line1_mem [MAX_WIDTH];
    pixel_t line2_mem [MAX_WIDTH];

    pixel_t     rd1_reg;
    pixel_t     rd2_reg;
    logic       a_valid_reg;
    tap_ctl_t   a_ctl_reg;
    pixel_t     a_pix_reg;
    logic [COL_W-1:0] a_col_reg;
    logic       fwd_reg;
    pixel_t     fwd1_reg;
    pixel_t     fwd2_reg;

    logic   rd_en;
    logic   wr_en;
    pixel_t row1;
    pixel_t row2;

    assign rd_en = advance && in_valid;
    assign wr_en = advance && a_valid_reg;
    // one-pixel rows hit the column still being written: forward it
    assign row1  = fwd_reg ? fwd1_reg : rd1_reg;
    assign row2  = fwd_reg ? fwd2_reg : rd2_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            line1_mem[a_col_reg] <= a_pix_reg;
        end
        if (rd_en) begin
            rd1_reg <= line1_mem[in_col];
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            line2_mem[a_col_reg] <= row1;
        end
        if (rd_en) begin
            rd2_reg <= line2_mem[in_col];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (advance) begin
            a_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            a_ctl_reg <= in_ctl;
            a_pix_reg <= in_pixel;
            a_col_reg <= in_col;
            fwd_reg   <= a_valid_reg && (a_col_reg == in_col);
            fwd1_reg  <= a_pix_reg;
            fwd2_reg  <= row1;
        end
    end

    assign a_valid         = a_valid_reg;
    assign a_ctl           = a_ctl_reg;
    assign a_column.bottom = a_pix_reg;
    assign a_column.middle = row1;
    assign a_column.top    = row2;

endmodule

FILE: hw/rtl/bb3_window_sum.sv
// ============================================================================
// bb3_window_sum: 3x3 window and masked neighborhood sum
// Shifts each column into the window and registers sum and neighbor count.
// ============================================================================
module bb3_window_sum (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               advance,
    input  logic               a_valid,
    input  bb3_pkg::tap_ctl_t  a_ctl,
    input  bb3_pkg::column_t   a_column,
    output logic               b_valid,
    output bb3_pkg::sum_t      b_sum,
    output logic [3:0]         b_count,
    output logic               b_last
);
    import bb3_pkg::*;

    function automatic csum_t col_sum(input column_t c, input logic top_ok,
                                      input logic bot_ok);
        csum_t s;
        s.red   = 10'(c.middle.red)
                + (top_ok ? 10'(c.top.red)    : 10'd0)
                + (bot_ok ? 10'(c.bottom.red) : 10'd0);
        s.green = 10'(c.middle.green)
                + (top_ok ? 10'(c.top.green)    : 10'd0)
                + (bot_ok ? 10'(c.bottom.green) : 10'd0);
        s.blue  = 10'(c.middle.blue)
                + (top_ok ? 10'(c.top.blue)    : 10'd0)
                + (bot_ok ? 10'(c.bottom.blue) : 10'd0);
        return s;
    endfunction

    column_t     left_reg;
    column_t     center_reg;
    logic        b_valid_reg;
    sum_t        b_sum_reg;
    logic [3:0]  b_count_reg;
    logic        b_last_reg;

    csum_t       sl;
    csum_t       sc;
    csum_t       sr;
    sum_t        sum_next;
    logic [1:0]  vcnt;
    logic [1:0]  hcnt;
    logic [3:0]  count_next;

    // after the shift: left = old center, center = newest-but-one, right = new
    always_comb begin
        sl = col_sum(left_reg, a_ctl.top_ok, a_ctl.bot_ok);
        sc = col_sum(center_reg, a_ctl.top_ok, a_ctl.bot_ok);
        sr = col_sum(a_column, a_ctl.top_ok, a_ctl.bot_ok);
        sum_next.red   = 12'(sc.red)
                       + (a_ctl.left_ok  ? 12'(sl.red) : 12'd0)
                       + (a_ctl.right_ok ? 12'(sr.red) : 12'd0);
        sum_next.green = 12'(sc.green)
                       + (a_ctl.left_ok  ? 12'(sl.green) : 12'd0)
                       + (a_ctl.right_ok ? 12'(sr.green) : 12'd0);
        sum_next.blue  = 12'(sc.blue)
                       + (a_ctl.left_ok  ? 12'(sl.blue) : 12'd0)
                       + (a_ctl.right_ok ? 12'(sr.blue) : 12'd0);
        vcnt = 2'd1 + 2'(a_ctl.top_ok) + 2'(a_ctl.bot_ok);
        hcnt = 2'd1 + 2'(a_ctl.left_ok) + 2'(a_ctl.right_ok);
        count_next = 4'(vcnt) * 4'(hcnt);
    end

    always_ff @(posedge aclk) begin
        if (advance && a_valid) begin
            left_reg   <= center_reg;
            center_reg <= a_column;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (advance) begin
            b_valid_reg <= a_valid && a_ctl.emit;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            b_sum_reg   <= sum_next;
            b_count_reg <= count_next;
            b_last_reg  <= a_ctl.last;
        end
    end

    assign b_valid = b_valid_reg;
    assign b_sum   = b_sum_reg;
    assign b_count = b_count_reg;
    assign b_last  = b_last_reg;

endmodule

FILE: hw/rtl/bb3_mean.sv
// ============================================================================
// bb3_mean: rounded mean and output register with skid stage
// Divides each sum by its count through a reciprocal multiply.
// ============================================================================
module bb3_mean (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             b_valid,
    input  bb3_pkg::sum_t    b_sum,
    input  logic [3:0]       b_count,
    input  logic             b_last,
    output logic             advance,
    output logic             m_tvalid,
    input  logic             m_tready,
    output bb3_pkg::pixel_t  out_pixel,
    output logic             out_last
);
    import bb3_pkg::*;

    // (2*sum + count) / (2*count), exact for sums of up to nine pixels
    function automatic logic [7:0] mean8(input logic [11:0] sum, input logic [3:0] count);
        logic [12:0] x;
        logic [32:0] prod;
        x    = {sum, 1'b0} + 13'(count);
        prod = 33'(x) * 33'(recip_2n(count));
        return prod[RECIP_SHIFT+7:RECIP_SHIFT];
    endfunction

    logic   out_valid_reg, out_valid_next;
    pixel_t out_pix_reg, out_pix_next;
    logic   out_last_reg, out_last_next;
    logic   skid_valid_reg, skid_valid_next;
    pixel_t skid_pix_reg, skid_pix_next;
    logic   skid_last_reg, skid_last_next;
    pixel_t res;

    always_comb begin
        res.red   = mean8(b_sum.red, b_count);
        res.green = mean8(b_sum.green, b_count);
        res.blue  = mean8(b_sum.blue, b_count);

        out_valid_next  = out_valid_reg;
        out_pix_next    = out_pix_reg;
        out_last_next   = out_last_reg;
        skid_valid_next = skid_valid_reg;
        skid_pix_next   = skid_pix_reg;
        skid_last_next  = skid_last_reg;

        if (skid_valid_reg) begin
            // pipeline holds; refill the output from the skid stage
            if (m_tready) begin
                out_pix_next    = skid_pix_reg;
                out_last_next   = skid_last_reg;
                skid_valid_next = 1'b0;
            end
        end else if (!out_valid_reg || m_tready) begin
            out_valid_next = b_valid;
            if (b_valid) begin
                out_pix_next  = res;
                out_last_next = b_last;
            end
        end else if (b_valid) begin
            skid_valid_next = 1'b1;
            skid_pix_next   = res;
            skid_last_next  = b_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_pix_reg   <= out_pix_next;
        out_last_reg  <= out_last_next;
        skid_pix_reg  <= skid_pix_next;
        skid_last_reg <= skid_last_next;
    end

    assign advance   = !skid_valid_reg;
    assign m_tvalid  = out_valid_reg;
    assign out_pixel = out_pix_reg;
    assign out_last  = out_last_reg;

endmodule
